// File: rtl/unsigned_to_decimal_ascii_macros.svh
// Assertion helpers for the decimal ASCII converter.
// Both expect clk and rst_n in scope at the point of use.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define U2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define U2DA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U2DA_ASSERT(lbl, prop, msg)
`define U2DA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/u2da_pkg.sv
`default_nettype none

package u2da_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int CAP_W   = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 16'd11;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'h30;
  localparam logic [DIGIT_W-1:0] DABBLE_LIM = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input value, clear the BCD word
    logic shift;  // one double-dabble step
    logic count;  // size the result and check it against the buffer
    logic next;   // step to the next lower digit
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic shift_done;  // current step is the final one
    logic last;        // current result closes the transaction
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/u2da_ctrl.sv
`default_nettype none

module u2da_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output u2da_pkg::cmd_t     cmd,
  input  wire u2da_pkg::sts_t sts
);

  u2da_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      u2da_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = u2da_pkg::ST_CONV;
        end
      end
      u2da_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = u2da_pkg::ST_COUNT;
        end
      end
      u2da_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = u2da_pkg::ST_EMIT;
      end
      u2da_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = u2da_pkg::ST_IDLE;
          end else begin
            cmd.next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = u2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u2da_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u2da_dp.sv
`default_nettype none

module u2da_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10,
  localparam int NDIG   = ((VALUE_WIDTH * 1233) >> 12) + 1,
  localparam int BCD_W  = NDIG * u2da_pkg::DIGIT_W,
  localparam int SH_W   = $clog2(VALUE_WIDTH),
  localparam int CNTF_W = $clog2(NDIG + 1),
  localparam int IDX_W  = $clog2(NDIG),
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [VALUE_WIDTH-1:0]        in_value,
  input  wire logic                          cfg_we,
  input  wire logic [u2da_pkg::CAP_W-1:0]    cfg_buffer_capacity,
  input  wire u2da_pkg::cmd_t                cmd,
  output u2da_pkg::sts_t                     sts,
  output logic [u2da_pkg::CHAR_W-1:0]        out_digit_char,
  output logic [CNT_W-1:0]                   out_num_digits,
  output logic                               out_fits,
  output logic                               out_last
);

  logic [u2da_pkg::CAP_W-1:0] cap_r;
  logic [VALUE_WIDTH-1:0]     val_r, val_nxt;
  logic [BCD_W-1:0]           bcd_r, bcd_nxt, bcd_adj;
  logic [SH_W-1:0]            sh_cnt_r, sh_cnt_nxt;
  logic [CNTF_W-1:0]          cnt_r, cnt_nxt, cnt_calc;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       refuse_r, refuse_nxt, refuse_calc;
  logic [u2da_pkg::DIGIT_W-1:0] cur_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= u2da_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_buffer_capacity;
    end
  end

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    logic [u2da_pkg::DIGIT_W-1:0] dig;
    for (int i = 0; i < NDIG; i++) begin
      dig = bcd_r[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W];
      bcd_adj[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] =
        (dig >= u2da_pkg::DABBLE_LIM) ? dig + u2da_pkg::DABBLE_ADD : dig;
    end
  end

  // highest nonzero digit sets the count; zero still has one digit
  always_comb begin
    cnt_calc = CNTF_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_r[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] != '0) begin
        cnt_calc = CNTF_W'(i + 1);
      end
    end
  end

  assign refuse_calc = (u2da_pkg::CAP_W'(cnt_calc) >= cap_r) ||
                       (32'(cnt_calc) > 32'(MAX_DIGITS));

  always_comb begin
    val_nxt    = val_r;
    bcd_nxt    = bcd_r;
    sh_cnt_nxt = sh_cnt_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    refuse_nxt = refuse_r;
    if (cmd.load) begin
      val_nxt    = in_value;
      bcd_nxt    = '0;
      sh_cnt_nxt = '0;
    end
    if (cmd.shift) begin
      bcd_nxt    = {bcd_adj[BCD_W-2:0], val_r[VALUE_WIDTH-1]};
      val_nxt    = {val_r[VALUE_WIDTH-2:0], 1'b0};
      sh_cnt_nxt = sh_cnt_r + SH_W'(1);
    end
    if (cmd.count) begin
      cnt_nxt    = cnt_calc;
      refuse_nxt = refuse_calc;
      idx_nxt    = refuse_calc ? '0 : IDX_W'(cnt_calc - CNTF_W'(1));
    end
    if (cmd.next) begin
      idx_nxt = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    bcd_r    <= bcd_nxt;
    sh_cnt_r <= sh_cnt_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    refuse_r <= refuse_nxt;
  end

  assign sts.shift_done = (sh_cnt_r == SH_W'(VALUE_WIDTH - 1));
  assign sts.last       = refuse_r || (idx_r == '0);

  assign cur_digit = bcd_r[idx_r*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W];

  assign out_digit_char  = refuse_r ? '0 :
                           u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(cur_digit);
  // on a fitting result the count is at most MAX_DIGITS
  assign out_num_digits  = refuse_r ? '0 : CNT_W'(cnt_r);
  assign out_fits        = !refuse_r;
  assign out_last        = sts.last;

endmodule

`default_nettype wire

// File: rtl/unsigned_to_decimal_ascii.sv
// Unsigned binary to decimal ASCII converter.
// Input channel in_valid/in_ready/in_value: one unsigned number per
// transaction. Output channel out_valid/out_ready carries one decimal digit
// per transaction, most significant first: out_digit_char ('0'..'9'),
// out_num_digits (digits in the whole number), out_fits, and out_last on
// the final digit. Zero gives the single digit '0'.
// cfg_valid/cfg_ready/cfg_buffer_capacity sets the buffer size (reset 11);
// when the digit count reaches it, or exceeds MAX_DIGITS, a single
// transaction comes out with fits, count and char all zero and last set.
// Timing: one number at a time. Once a number is accepted, the controller
// runs the double-dabble shift steps (ST_CONV) and then the sizing step
// (ST_COUNT) before the first digit can be taken. Digits then go out at
// one per cycle while out_ready is high; a stall holds the current digit.
// The next number is taken the cycle after out_last is accepted. Most of
// the time per number goes to the shift loop through the BCD register.
// Reset (synchronous, rst_n low) drops any conversion in flight and restores
// the buffer capacity to 11; in_ready and cfg_ready stay low while it is held.
`default_nettype none

`include "unsigned_to_decimal_ascii_macros.svh"

module unsigned_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [VALUE_WIDTH-1:0]              in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [u2da_pkg::CHAR_W-1:0]              out_digit_char,
  output logic [$clog2(MAX_DIGITS+1)-1:0]          out_num_digits,
  output logic                                     out_fits,
  output logic                                     out_last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [u2da_pkg::CAP_W-1:0]          cfg_buffer_capacity
);

  u2da_pkg::cmd_t cmd;
  u2da_pkg::sts_t sts;

  assign cfg_ready = rst_n;

  u2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  u2da_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_value            (in_value),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_buffer_capacity (cfg_buffer_capacity),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_digit_char      (out_digit_char),
    .out_num_digits      (out_num_digits),
    .out_fits            (out_fits),
    .out_last            (out_last)
  );

  `U2DA_ASSERT_ALWAYS(a_reset_idle, !rst_n ##1 rst_n |-> in_ready && !out_valid, "not idle")
  `U2DA_ASSERT(a_one_at_a_time, !(in_ready && out_valid), "input taken while emitting")
  `U2DA_ASSERT(a_last_frees, out_valid && out_ready && out_last |=> in_ready, "stuck after last")
  `U2DA_ASSERT(a_refusal_form, out_valid && !out_fits |-> out_last && out_num_digits == '0 && out_digit_char == '0, "malformed refusal")
  `U2DA_ASSERT(a_digit_range, out_valid && out_fits |-> out_digit_char >= 6'h30 && out_digit_char <= 6'h39, "digit out of range")

endmodule

`default_nettype wire

// File: dv/unsigned_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps

module unsigned_to_decimal_ascii_tb;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 10;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [u2da_pkg::CHAR_W-1:0] char_code;
    logic [3:0]                  num_digits;
    logic                        fits;
    logic                        last;
  } digit_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [VALUE_WIDTH-1:0]        in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [u2da_pkg::CHAR_W-1:0]   out_digit_char;
  logic [3:0]                    out_num_digits;
  logic                          out_fits;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [u2da_pkg::CAP_W-1:0]    cfg_buffer_capacity = '0;

  digit_t                        digits_due[$];
  logic [u2da_pkg::CAP_W-1:0]    capacity_now = u2da_pkg::CAP_RESET;
  int                            mismatches = 0;
  int                            sender_idle_pct = 35;
  int                            receiver_idle_pct = 56;
  int                            receiver_hold = 0;
  int                            stall_cycles = 0;

  unsigned_to_decimal_ascii #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_digit_char      (out_digit_char),
    .out_num_digits      (out_num_digits),
    .out_fits            (out_fits),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_buffer_capacity (cfg_buffer_capacity)
  );

  always #4 clk = ~clk;

  // Digits of one number, most significant first, or a single refusal.
  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] rest;
    logic [3:0]             dig [20];
    int                     n;
    digit_t                 d;
    rest = v;
    n = 0;
    do begin
      dig[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    if (n >= capacity_now || n > MAX_DIGITS) begin
      d = '{char_code: '0, num_digits: '0, fits: 1'b0, last: 1'b1};
      digits_due.push_back(d);
    end else begin
      for (int i = n - 1; i >= 0; i--) begin
        d.char_code  = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(dig[i]);
        d.num_digits = 4'(n);
        d.fits       = 1'b1;
        d.last       = (i == 0);
        digits_due.push_back(d);
      end
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    longint unsigned lo, hi;
    int unsigned     ndig;
    case ($urandom_range(3))
      0: random_value = $urandom;
      1: random_value = $urandom_range(99);
      default: begin
        // uniform over one decimal length
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
        random_value = $urandom_range(hi[31:0], lo[31:0]);
      end
    endcase
  endfunction

  function automatic logic [u2da_pkg::CAP_W-1:0] random_capacity();
    case ($urandom_range(7))
      0: random_capacity = u2da_pkg::CAP_W'($urandom_range(1));
      1: random_capacity = u2da_pkg::CAP_W'($urandom_range(10, 2));
      2: random_capacity = 16'hFFFF;
      default: random_capacity = u2da_pkg::CAP_W'($urandom_range(65535, 11));
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_digits(v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    // the next number is taken the cycle after the final digit is accepted
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [u2da_pkg::CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_buffer_capacity <= cap;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_now = cap;
  endtask

  // Capacity out of reset is 11: every 32-bit value fits.
  task automatic test_default_capacity();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd99);
    send_value(32'd100);
    send_value(32'hFFFF_FFFF);
    send_value(32'd999_999_999);
    send_value(32'd1_000_000_000);
    wait_drained();
  endtask

  task automatic test_refusal_capacities();
    write_capacity(16'd0);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    wait_drained();
    write_capacity(16'd1);
    send_value(32'd5);
    wait_drained();
    write_capacity(16'd2);
    send_value(32'd7);
    send_value(32'd10);
    wait_drained();
    // ten digits no longer leave room for the terminator
    write_capacity(16'd10);
    send_value(32'd999_999_999);
    send_value(32'd1_000_000_000);
    wait_drained();
  endtask

  task automatic test_widest_capacity();
    write_capacity(16'hFFFF);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd4_000_000_000);
    wait_drained();
  endtask

  // Output stalled long enough that the block backs up into its input.
  task automatic test_receiver_hold();
    receiver_hold = 300;
    repeat (6) send_value(random_value());
    wait_drained();
  endtask

  task automatic test_random_stream(input int n_items, input int send_pct,
                                    input int recv_pct);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        wait_drained();
        write_capacity(random_capacity());
      end
      send_value(random_value());
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : receive_digits
    digit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, %s %0d %0d %0b %0b",
                 $time, "actual char/count/fits/last", out_digit_char,
                 out_num_digits, out_fits, out_last);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if (out_digit_char !== want.char_code) begin
          $display("%0t: digit_char expected %0d actual %0d", $time, want.char_code,
                   out_digit_char);
          mismatches++;
        end
        if (out_num_digits !== want.num_digits) begin
          $display("%0t: num_digits expected %0d actual %0d", $time, want.num_digits,
                   out_num_digits);
          mismatches++;
        end
        if (out_fits !== want.fits) begin
          $display("%0t: fits expected %0b actual %0b", $time, want.fits, out_fits);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
    if (receiver_hold > 0) begin
      receiver_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_capacity();
    test_refusal_capacities();
    test_widest_capacity();
    test_receiver_hold();
    test_random_stream(66, 35, 56);
    test_random_stream(66, 56, 35);
    test_random_stream(66, 0, 0);
    repeat (VALUE_WIDTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/u2da_pkg.sv
rtl/u2da_ctrl.sv
rtl/u2da_dp.sv
rtl/unsigned_to_decimal_ascii.sv
dv/unsigned_to_decimal_ascii_tb.sv
